>>> hdl/serial_file_download_receiver_core_assert.svh
// Assertion macros shared by the receiver modules.
// Each macro expects clk and rst_n in scope.
`ifndef SERIAL_FILE_DOWNLOAD_RECEIVER_CORE_ASSERT_SVH
`define SERIAL_FILE_DOWNLOAD_RECEIVER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SFDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFDR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SFDR_ASSERT(lbl, prop, msg)
`define SFDR_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/sfdr_pkg.sv
package sfdr_pkg;

  localparam int PAGE_BYTES = 64;
  localparam int SLOT_BYTES = 16384;
  localparam int NAME_BYTES = 16;

  localparam int PAGES_PER_SLOT = SLOT_BYTES / PAGE_BYTES;
  localparam int PAGE_W = 10;
  localparam int OFF_W  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int NAME_IW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam int SIZE_W = $clog2(SLOT_BYTES + 1);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CODE_START = 8'h53;
  localparam logic [7:0] CODE_ACK   = 8'h41;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic [2:0] KIND_TX     = 3'd0;
  localparam logic [2:0] KIND_STORE  = 3'd1;
  localparam logic [2:0] KIND_COMMIT = 3'd2;
  localparam logic [2:0] KIND_NAME   = 3'd3;
  localparam logic [2:0] KIND_SIZE   = 3'd4;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_NAME   = 2'd1;
  localparam logic [1:0] CMD_DATA   = 2'd2;
  localparam logic [1:0] CMD_RECORD = 2'd3;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [9:0]  page_address;
    logic [5:0]  byte_offset;
    logic [7:0]  value;
    logic [3:0]  name_position;
    logic [14:0] record_size;
    logic        last;
  } out_item_t;

  // command passed from the front end to the result sequencer
  typedef struct packed {
    logic [1:0]         op;
    logic               commit;
    logic               record;
    logic [PAGE_W-1:0]  page;
    logic [OFF_W-1:0]   offset;
    logic [7:0]         data;
    logic [NAME_IW-1:0] pos;
    logic [SIZE_W-1:0]  size;
  } cmd_t;

endpackage

>>> hdl/serial_file_download_receiver_core.sv
// Channel  Direction  Handshake             Word
// in_      input      in_valid / in_stall   sfdr_pkg::in_item_t
// out_     output     out_valid / out_stall sfdr_pkg::out_item_t
// cfg_     input      cfg_valid / cfg_ready cfg_slot_index
//
// An input word is taken whenever the four-entry command queue has room.
// The result sequencer fetches a command, then issues one result per cycle while the output
// is not stalled; the final data byte of a file yields a store, commit, ACK, NAME_BYTES names and size.
// Reset is synchronous and active low; the stored name holds no value until written.
// A stalled output holds its word; the front keeps taking input until the queue fills.
module serial_file_download_receiver_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfdr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sfdr_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_slot_index
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  sfdr_pkg::cmd_t push_cmd;
  sfdr_pkg::cmd_t pop_cmd;

  sfdr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_slot_index (cfg_slot_index),
    .q_push         (q_push),
    .q_cmd          (push_cmd),
    .q_full         (q_full)
  );

  sfdr_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  sfdr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (pop_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> hdl/sfdr_front.sv
module sfdr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sfdr_pkg::in_item_t in_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_slot_index,
  output logic              q_push,
  output sfdr_pkg::cmd_t    q_cmd,
  input  logic              q_full
);

  `include "serial_file_download_receiver_core_assert.svh"

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_WAIT_ACK  = 3'd1;
  localparam logic [2:0] PH_NAME      = 3'd2;
  localparam logic [2:0] PH_SIZE_HIGH = 3'd3;
  localparam logic [2:0] PH_SIZE_LOW  = 3'd4;
  localparam logic [2:0] PH_DATA      = 3'd5;

  logic [2:0]                     phase_r, phase_nxt;
  logic [1:0]                     slot_r, slot_nxt;
  logic [sfdr_pkg::NAME_IW-1:0]   name_count_r, name_count_nxt;
  logic [7:0]                     size_high_r, size_high_nxt;
  logic [sfdr_pkg::SIZE_W-1:0]    total_r, total_nxt;
  logic [sfdr_pkg::SIZE_W-1:0]    remaining_r, remaining_nxt;
  logic [sfdr_pkg::OFF_W-1:0]     chunk_r, chunk_nxt;
  logic [sfdr_pkg::PAGE_W-1:0]    page_r, page_nxt;

  logic                           accept;
  logic [15:0]                    raw_size;
  logic [sfdr_pkg::SIZE_W-1:0]    clamp_size;
  logic [sfdr_pkg::SIZE_W-1:0]    rem_dec;
  logic [sfdr_pkg::PAGE_W-1:0]    start_page;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  assign raw_size   = {size_high_r, in_item.rx_byte};
  assign clamp_size = (raw_size > 16'(sfdr_pkg::SLOT_BYTES)) ?
                      sfdr_pkg::SIZE_W'(sfdr_pkg::SLOT_BYTES) :
                      sfdr_pkg::SIZE_W'(raw_size);
  assign rem_dec    = remaining_r - sfdr_pkg::SIZE_W'(1);
  assign start_page = sfdr_pkg::PAGE_W'(32'(slot_r) * 32'(sfdr_pkg::PAGES_PER_SLOT));

  always_comb begin
    phase_nxt      = phase_r;
    slot_nxt       = slot_r;
    name_count_nxt = name_count_r;
    size_high_nxt  = size_high_r;
    total_nxt      = total_r;
    remaining_nxt  = remaining_r;
    chunk_nxt      = chunk_r;
    page_nxt       = page_r;
    q_push         = 1'b0;
    q_cmd          = '0;

    if (cfg_valid && cfg_ready) begin
      slot_nxt = cfg_slot_index;
    end

    if (accept) begin
      if (in_item.opcode == sfdr_pkg::OP_START) begin
        // drop any transfer in progress
        phase_nxt      = PH_WAIT_ACK;
        name_count_nxt = '0;
        size_high_nxt  = '0;
        total_nxt      = '0;
        remaining_nxt  = '0;
        chunk_nxt      = '0;
        page_nxt       = start_page;
        q_push         = 1'b1;
        q_cmd.op       = sfdr_pkg::CMD_START;
      end else begin
        unique case (phase_r)
          PH_WAIT_ACK: begin
            if (in_item.rx_byte == sfdr_pkg::CODE_ACK) begin
              phase_nxt      = PH_NAME;
              name_count_nxt = '0;
            end
          end
          PH_NAME: begin
            q_push     = 1'b1;
            q_cmd.op   = sfdr_pkg::CMD_NAME;
            q_cmd.pos  = name_count_r;
            q_cmd.data = in_item.rx_byte;
            if (name_count_r == sfdr_pkg::NAME_IW'(sfdr_pkg::NAME_BYTES - 1)) begin
              phase_nxt = PH_SIZE_HIGH;
            end else begin
              name_count_nxt = name_count_r + sfdr_pkg::NAME_IW'(1);
            end
          end
          PH_SIZE_HIGH: begin
            size_high_nxt = in_item.rx_byte;
            phase_nxt     = PH_SIZE_LOW;
          end
          PH_SIZE_LOW: begin
            total_nxt     = clamp_size;
            remaining_nxt = clamp_size;
            chunk_nxt     = '0;
            if (clamp_size == '0) begin
              q_push     = 1'b1;
              q_cmd.op   = sfdr_pkg::CMD_RECORD;
              q_cmd.size = clamp_size;
              phase_nxt  = PH_IDLE;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            q_push        = 1'b1;
            q_cmd.op      = sfdr_pkg::CMD_DATA;
            q_cmd.page    = page_r;
            q_cmd.offset  = chunk_r;
            q_cmd.data    = in_item.rx_byte;
            q_cmd.size    = total_r;
            q_cmd.commit  = (chunk_r == sfdr_pkg::OFF_W'(sfdr_pkg::PAGE_BYTES - 1)) ||
                            (rem_dec == '0);
            q_cmd.record  = (rem_dec == '0);
            remaining_nxt = rem_dec;
            if (q_cmd.commit) begin
              page_nxt  = page_r + sfdr_pkg::PAGE_W'(1);
              chunk_nxt = '0;
            end else begin
              chunk_nxt = chunk_r + sfdr_pkg::OFF_W'(1);
            end
            if (q_cmd.record) begin
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            // idle: stray bytes are ignored
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      slot_r       <= '0;
      name_count_r <= '0;
      size_high_r  <= '0;
      total_r      <= '0;
      remaining_r  <= '0;
      chunk_r      <= '0;
      page_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      slot_r       <= slot_nxt;
      name_count_r <= name_count_nxt;
      size_high_r  <= size_high_nxt;
      total_r      <= total_nxt;
      remaining_r  <= remaining_nxt;
      chunk_r      <= chunk_nxt;
      page_r       <= page_nxt;
    end
  end

  `SFDR_ASSERT_IMP(a_data_has_bytes, phase_r == PH_DATA, remaining_r != '0, "data phase with nothing left")

endmodule

>>> hdl/sfdr_cmd_queue.sv
module sfdr_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sfdr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output sfdr_pkg::cmd_t pop_cmd,
  output logic           empty
);

  `include "serial_file_download_receiver_core_assert.svh"

  sfdr_pkg::cmd_t                entries_r [sfdr_pkg::Q_DEPTH];
  logic [sfdr_pkg::Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [sfdr_pkg::Q_CNT_W-1:0]  count_r;

  assign full    = (count_r == sfdr_pkg::Q_CNT_W'(sfdr_pkg::Q_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + sfdr_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + sfdr_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + sfdr_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - sfdr_pkg::Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  `SFDR_ASSERT(a_no_overflow, !(push && full), "word pushed into full queue")
  `SFDR_ASSERT(a_no_underflow, !(pop && empty), "word popped from empty queue")

endmodule

>>> hdl/sfdr_back.sv
module sfdr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sfdr_pkg::cmd_t      q_cmd,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output sfdr_pkg::out_item_t out_item
);

  `include "serial_file_download_receiver_core_assert.svh"

  localparam logic [2:0] SEQ_START  = 3'd0;
  localparam logic [2:0] SEQ_STORE  = 3'd1;
  localparam logic [2:0] SEQ_COMMIT = 3'd2;
  localparam logic [2:0] SEQ_ACK    = 3'd3;
  localparam logic [2:0] SEQ_NAME   = 3'd4;
  localparam logic [2:0] SEQ_SIZE   = 3'd5;

  logic                          busy_r, busy_nxt;
  sfdr_pkg::cmd_t                cmd_r;
  logic [2:0]                    seq_r, seq_nxt;
  logic [sfdr_pkg::NAME_IW-1:0]  k_r, k_nxt;
  logic [7:0]                    name_r [sfdr_pkg::NAME_BYTES];
  logic                          out_valid_r;
  sfdr_pkg::out_item_t           out_item_r;

  sfdr_pkg::out_item_t           res;
  logic                          load;
  logic                          fetch;

  assign q_pop     = !busy_r && !q_empty;
  assign fetch     = q_pop && (q_cmd.op != sfdr_pkg::CMD_NAME);
  assign load      = busy_r && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // current result and the step after it
  always_comb begin
    res      = '0;
    seq_nxt  = seq_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    unique case (seq_r)
      SEQ_START: begin
        res.kind    = sfdr_pkg::KIND_TX;
        res.tx_byte = sfdr_pkg::CODE_START;
        res.last    = 1'b1;
      end
      SEQ_STORE: begin
        res.kind         = sfdr_pkg::KIND_STORE;
        res.page_address = cmd_r.page;
        res.byte_offset  = 6'(cmd_r.offset);
        res.value        = cmd_r.data;
        res.last         = !cmd_r.commit;
        seq_nxt          = SEQ_COMMIT;
      end
      SEQ_COMMIT: begin
        res.kind         = sfdr_pkg::KIND_COMMIT;
        res.page_address = cmd_r.page;
        seq_nxt          = SEQ_ACK;
      end
      SEQ_ACK: begin
        res.kind    = sfdr_pkg::KIND_TX;
        res.tx_byte = sfdr_pkg::CODE_ACK;
        res.last    = !cmd_r.record;
        seq_nxt     = SEQ_NAME;
        k_nxt       = '0;
      end
      SEQ_NAME: begin
        res.kind          = sfdr_pkg::KIND_NAME;
        res.value         = name_r[k_r];
        res.name_position = 4'(k_r);
        if (k_r == sfdr_pkg::NAME_IW'(sfdr_pkg::NAME_BYTES - 1)) begin
          seq_nxt = SEQ_SIZE;
        end else begin
          k_nxt = k_r + sfdr_pkg::NAME_IW'(1);
        end
      end
      SEQ_SIZE: begin
        res.kind        = sfdr_pkg::KIND_SIZE;
        res.record_size = 15'(cmd_r.size);
        res.last        = 1'b1;
      end
      default: begin
        res.last = 1'b1;
      end
    endcase
    if (res.last) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      seq_r       <= SEQ_START;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fetch) begin
        busy_r <= 1'b1;
        k_r    <= '0;
        unique case (q_cmd.op)
          sfdr_pkg::CMD_START:  seq_r <= SEQ_START;
          sfdr_pkg::CMD_DATA:   seq_r <= SEQ_STORE;
          sfdr_pkg::CMD_RECORD: seq_r <= SEQ_NAME;
          default:              seq_r <= SEQ_START;
        endcase
      end else if (load) begin
        busy_r <= busy_nxt;
        seq_r  <= seq_nxt;
        k_r    <= k_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch) begin
      cmd_r <= q_cmd;
    end
    if (load) begin
      out_item_r <= res;
    end
    // name bytes land in order with the commands around them
    if (q_pop && q_cmd.op == sfdr_pkg::CMD_NAME) begin
      name_r[q_cmd.pos] <= q_cmd.data;
    end
  end

  `SFDR_ASSERT_IMP(a_commit_flagged, busy_r && seq_r == SEQ_COMMIT, cmd_r.commit, "commit without flag")
  `SFDR_ASSERT_IMP(a_record_flagged, busy_r && (seq_r == SEQ_NAME || seq_r == SEQ_SIZE), cmd_r.op == sfdr_pkg::CMD_RECORD || cmd_r.record, "record without flag")

endmodule
